>>> hdl/sha384he_pkg.sv
// Shared types and constant tables for the SHA-384 hash engine.
package sha384he_pkg;

  // One input beat: absorb a byte or finish the message.
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  // One output beat: a single digest word.
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Eight working variables a..h, index 0 is a.
  typedef logic [7:0][63:0] vars_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZFILL,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EREAD,
    ST_ELOAD
  } state_e;

  localparam logic       ACT_ABSORB = 1'b0;
  localparam logic       ACT_FINISH = 1'b1;
  localparam int         NumRounds  = 80;
  localparam logic [6:0] LastRound  = 7'(NumRounds - 1);
  localparam logic [2:0] LastWord   = 3'd5;

  localparam logic [63:0] IV_TAB [8] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
    64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
    64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
  };

  localparam logic [63:0] RC_TAB [NumRounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

>>> hdl/sha384he_round.sv
// One SHA-512-family compression round on the working variables.
module sha384he_round (
  input  sha384he_pkg::vars_t v_i,
  input  logic [63:0]         w_i,
  input  logic [63:0]         k_i,
  output sha384he_pkg::vars_t v_o
);
  import sha384he_pkg::*;

  logic [63:0] sig1, sig0, ch, maj, t1, t2;

  // Sigma and choose/majority terms.
  always_comb begin
    sig1 = rotr(v_i[4], 14) ^ rotr(v_i[4], 18) ^ rotr(v_i[4], 41);
    sig0 = rotr(v_i[0], 28) ^ rotr(v_i[0], 34) ^ rotr(v_i[0], 39);
    ch   = v_i[6] ^ (v_i[4] & (v_i[5] ^ v_i[6]));
    maj  = (v_i[0] & v_i[1]) | (v_i[2] & (v_i[0] | v_i[1]));
    t1   = v_i[7] + sig1 + ch + k_i + w_i;
    t2   = sig0 + maj;
  end

  // Rotate the variables and insert the new a and e.
  always_comb begin
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

>>> hdl/sha384_hash_engine_unit.sv
// SHA-384 engine top level: byte packing, padding, compression sequencer and digest output.
// Usage: bytes are packed into 64-bit words of a 16-entry block memory. The absorb beat
// that completes a 128-byte block starts a compression (load the block and chaining
// words from memory, 80 rounds through one round unit, then read, add and write back the
// chaining memory) during which no input is taken. A finish beat writes the padded last
// word and zero-fills each remaining word of the block (up to 15, the two length words
// included), then runs one or two compressions, an extra block being zero-filled in full
// before its compression, then reads the six digest words out of the chaining memory,
// each read and then loaded into the output register. The output register lets a new
// message start while the last digest word waits.
module sha384_hash_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha384he_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha384he_pkg::out_t out_data_o
);
  import sha384he_pkg::*;

  state_e state_q, state_d;

  logic [127:0] count_q;
  logic [55:0]  pack_q;
  logic [4:0]   cnt_q;
  logic [6:0]   rnd_q;
  logic [3:0]   fp_q;
  logic [2:0]   ek_q;
  logic         fin_q, extra_q;
  logic [7:0]   cvalid_q;
  logic         ovalid_q;
  out_t         odata_q;

  vars_t        v_q, v_rnd;
  logic [15:0][63:0] w_q;
  logic [63:0]  w_new;

  // Block memory and chaining memory.
  logic [63:0] buf_mem [16];
  logic [63:0] chain_mem [8];
  logic        bwe, bre, cwe, cre;
  logic [3:0]  bwaddr, braddr;
  logic [2:0]  cwaddr, craddr, craddr_q;
  logic [63:0] bwdata, cwdata, brd_q, crd_q, chain_rd;
  logic        chit_q;

  logic        in_acc, absorb, finish, out_free;
  logic [3:0]  wi;
  logic [2:0]  bp;
  logic [63:0] pad_word, zfill_word, len_hi, len_lo;

  assign in_acc   = in_valid_i && in_ready_o;
  assign absorb   = in_acc && (in_data_i.action == ACT_ABSORB);
  assign finish   = in_acc && (in_data_i.action == ACT_FINISH);
  assign out_free = !ovalid_q || out_ready_i;
  assign wi       = count_q[6:3];
  assign bp       = count_q[2:0];
  assign len_hi   = {count_q[124:64], count_q[63:61]};
  assign len_lo   = {count_q[60:0], 3'b000};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // Unwritten chaining entries read as the initial value.
  assign chain_rd = chit_q ? crd_q : IV_TAB[craddr_q];

  // Last partial word with the 0x80 marker appended.
  always_comb begin
    unique case (bp)
      3'd0: pad_word = {8'h80, 56'h0};
      3'd1: pad_word = {pack_q[7:0], 8'h80, 48'h0};
      3'd2: pad_word = {pack_q[15:0], 8'h80, 40'h0};
      3'd3: pad_word = {pack_q[23:0], 8'h80, 32'h0};
      3'd4: pad_word = {pack_q[31:0], 8'h80, 24'h0};
      3'd5: pad_word = {pack_q[39:0], 8'h80, 16'h0};
      3'd6: pad_word = {pack_q[47:0], 8'h80, 8'h0};
      default: pad_word = {pack_q[55:0], 8'h80};
    endcase
  end

  // Zero fill, with the bit length in the last two words of the final block.
  always_comb begin
    priority if (!extra_q && fp_q == 4'd14) begin
      zfill_word = len_hi;
    end else if (!extra_q && fp_q == 4'd15) begin
      zfill_word = len_lo;
    end else begin
      zfill_word = '0;
    end
  end

  // Message schedule word sixteen rounds ahead.
  assign w_new = (rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6)) + w_q[9]
               + (rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7)) + w_q[0];

  sha384he_round u_round (
    .v_i (v_q),
    .w_i (w_q[0]),
    .k_i (RC_TAB[rnd_q]),
    .v_o (v_rnd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (finish) begin
          state_d = ST_PAD;
        end else if (absorb && count_q[6:0] == 7'h7F) begin
          state_d = ST_LOAD;
        end
      end
      ST_PAD:   state_d = (wi == 4'd15) ? ST_LOAD : ST_ZFILL;
      ST_ZFILL: if (fp_q == 4'd15) state_d = ST_LOAD;
      ST_LOAD:  if (cnt_q == 5'd16) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == LastRound) state_d = ST_FINAL;
      ST_FINAL: begin
        if (cnt_q == 5'd8) begin
          priority if (fin_q && extra_q) begin
            state_d = ST_ZFILL;
          end else if (fin_q) begin
            state_d = ST_EREAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EREAD: state_d = ST_ELOAD;
      ST_ELOAD: if (out_free) state_d = (ek_q == LastWord) ? ST_IDLE : ST_EREAD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    bwe    = 1'b0;
    bwaddr = wi;
    bwdata = pad_word;
    bre    = 1'b0;
    braddr = cnt_q[3:0];
    cwe    = 1'b0;
    cwaddr = 3'(cnt_q - 5'd1);
    cwdata = chain_rd + v_q[0];
    cre    = 1'b0;
    craddr = cnt_q[2:0];
    unique case (state_q)
      ST_IDLE: begin
        bwe    = absorb && (bp == 3'd7);
        bwdata = {pack_q, in_data_i.data_byte};
      end
      ST_PAD: bwe = 1'b1;
      ST_ZFILL: begin
        bwe    = 1'b1;
        bwaddr = fp_q;
        bwdata = zfill_word;
      end
      ST_LOAD: begin
        bre = (cnt_q < 5'd16);
        cre = (cnt_q < 5'd8);
      end
      ST_FINAL: begin
        cre = (cnt_q < 5'd8);
        cwe = (cnt_q != 5'd0);
      end
      ST_EREAD: begin
        cre    = 1'b1;
        craddr = ek_q;
      end
      default: ;
    endcase
  end

  // Block memory.
  always_ff @(posedge clk_i) begin
    if (bwe) buf_mem[bwaddr] <= bwdata;
    if (bre) brd_q <= buf_mem[braddr];
  end

  // Chaining memory.
  always_ff @(posedge clk_i) begin
    if (cwe) chain_mem[cwaddr] <= cwdata;
    if (cre) begin
      crd_q    <= chain_mem[craddr];
      craddr_q <= craddr;
    end
  end

  // Control state, counters and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cnt_q    <= '0;
      rnd_q    <= '0;
      fp_q     <= '0;
      ek_q     <= '0;
      fin_q    <= 1'b0;
      extra_q  <= 1'b0;
      cvalid_q <= '0;
      chit_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (absorb) count_q <= count_q + 128'd1;
      if (cre) chit_q <= cvalid_q[craddr];
      if (cwe) cvalid_q[cwaddr] <= 1'b1;
      // A new digest beat replaces the one taken in the same cycle.
      if (state_q == ST_ELOAD && out_free) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (finish) begin
            fin_q   <= 1'b1;
            extra_q <= (wi >= 4'd14);
          end
        end
        ST_PAD:   fp_q  <= wi + 4'd1;
        ST_ZFILL: fp_q  <= fp_q + 4'd1;
        ST_LOAD:  cnt_q <= (cnt_q == 5'd16) ? 5'd0 : cnt_q + 5'd1;
        ST_ROUND: rnd_q <= (rnd_q == LastRound) ? 7'd0 : rnd_q + 7'd1;
        ST_FINAL: begin
          cnt_q <= (cnt_q == 5'd8) ? 5'd0 : cnt_q + 5'd1;
          if (cnt_q == 5'd8 && fin_q && extra_q) begin
            extra_q <= 1'b0;
            fp_q    <= 4'd0;
          end
        end
        ST_ELOAD: begin
          if (out_free) begin
            ek_q <= (ek_q == LastWord) ? 3'd0 : ek_q + 3'd1;
            if (ek_q == LastWord) begin
              fin_q    <= 1'b0;
              count_q  <= '0;
              cvalid_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: byte packing, schedule window, working variables, output beat.
  always_ff @(posedge clk_i) begin
    if (absorb) pack_q <= {pack_q[47:0], in_data_i.data_byte};
    unique case (state_q)
      ST_LOAD: begin
        if (cnt_q != 5'd0) begin
          w_q <= {brd_q, w_q[15:1]};
          if (cnt_q <= 5'd8) v_q <= {chain_rd, v_q[7:1]};
        end
      end
      ST_ROUND: begin
        v_q <= v_rnd;
        w_q <= {w_new, w_q[15:1]};
      end
      ST_FINAL: if (cnt_q != 5'd0) v_q <= {v_q[0], v_q[7:1]};
      ST_ELOAD: begin
        if (out_free) begin
          odata_q.digest_word <= chain_rd;
          odata_q.word_index  <= ek_q;
          odata_q.last_word   <= (ek_q == LastWord);
        end
      end
      default: ;
    endcase
  end

  // The round counter only moves during the round phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (rnd_q == 7'd0))
    else $error("round counter left nonzero outside the round phase");

  // Write-back never targets the entry being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cwe && cre) |-> (cwaddr != craddr))
    else $error("chaining memory read and write collide");

  // A finish beat always starts padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == ST_PAD))
    else $error("finish beat did not start padding");

  // The last flag marks exactly the sixth digest word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == LastWord)))
    else $error("last word flag does not match word index");

endmodule
